[rtl/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the set-associative LRU cache core
// Holds request codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package salc_pkg;

    // Default geometry
    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 48;

    // Fixed field widths
    localparam int ADDRESS_W   = 48;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int BLOCK_BITS_MAX = 16;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_MODIFY = 2'd2;
    localparam logic [1:0] REQ_FETCH  = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd2;

    // Register reset values
    localparam logic [3:0] SET_BITS_RST   = 4'd4;
    localparam logic [3:0] WAYS_RST       = 4'd1;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

    typedef enum logic {
        B_IDLE,
        B_LOOK
    } back_state_t;

    typedef struct packed {
        logic               hit;
        logic               miss;
        logic               eviction;
        logic               last;
        logic [COUNT_W-1:0] hit_total;
        logic [COUNT_W-1:0] miss_total;
        logic [COUNT_W-1:0] eviction_total;
    } result_t;

endpackage

[rtl/salc_ram.sv]
// ----------------------------------------------------------------------------
// salc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[rtl/salc_fifo.sv]
// ----------------------------------------------------------------------------
// salc_fifo: small register FIFO
// Holds a few entries between two stages; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module salc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[rtl/salc_front.sv]
// ----------------------------------------------------------------------------
// salc_front: request intake and address split
// Drops instruction fetches, splits the address into set and tag, and queues
// one access record per request (modify marked for a repeat).
// ----------------------------------------------------------------------------
module salc_front #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      req_type,
    input  logic [salc_pkg::ADDRESS_W-1:0]  address,
    input  logic [4:0]                      set_bits_eff,
    input  logic [4:0]                      block_bits_eff,
    input  logic                            q_pop,
    output logic                            q_empty,
    output logic [MAX_SET_BITS-1:0]         q_set,
    output logic [((ADDR_BITS < salc_pkg::ADDRESS_W) ? ADDR_BITS
                   : salc_pkg::ADDRESS_W) - 3:0] q_tag,
    output logic                            q_dup
);

    localparam int EFF_BITS = (ADDR_BITS < salc_pkg::ADDRESS_W) ? ADDR_BITS
                              : salc_pkg::ADDRESS_W;
    localparam int TAG_W    = EFF_BITS - 2;
    localparam int SET_W    = MAX_SET_BITS;
    localparam int REC_W    = SET_W + TAG_W + 1;

    logic [EFF_BITS-1:0] addr;
    logic [EFF_BITS-1:0] above_block;
    logic [EFF_BITS-1:0] tag_full;
    logic [SET_W-1:0]    set_idx;
    logic [5:0]          tag_shift;
    logic                q_push;
    logic [REC_W-1:0]    q_wdata;
    logic [REC_W-1:0]    q_rdata;

    assign addr        = address[EFF_BITS-1:0];
    assign above_block = addr >> block_bits_eff;
    assign set_idx     = above_block[SET_W-1:0] & ~({SET_W{1'b1}} << set_bits_eff);
    assign tag_shift   = {1'b0, set_bits_eff} + {1'b0, block_bits_eff};
    assign tag_full    = addr >> tag_shift;

    // Fetches are taken and dropped here
    assign q_push  = push && !full && (req_type != salc_pkg::REQ_FETCH);
    assign q_wdata = {set_idx, tag_full[TAG_W-1:0], (req_type == salc_pkg::REQ_MODIFY)};

    salc_fifo #(
        .WIDTH(REC_W),
        .DEPTH(2)
    ) u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (q_push),
        .wdata(q_wdata),
        .pop  (q_pop),
        .rdata(q_rdata),
        .full (full),
        .empty(q_empty)
    );

    assign q_set = q_rdata[REC_W-1 -: SET_W];
    assign q_tag = q_rdata[TAG_W:1];
    assign q_dup = q_rdata[0];

endmodule

[rtl/salc_back.sv]
// ----------------------------------------------------------------------------
// salc_back: tag store lookup and LRU update
// Reads one set row, resolves hit, fill or eviction, writes the row back and
// emits a result record with the running totals.
// ----------------------------------------------------------------------------
module salc_back #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int TAG_W        = salc_pkg::ADDR_BITS_DEF - 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [$clog2(MAX_WAYS+1)-1:0]    ways_eff,
    input  logic                             q_empty,
    input  logic [MAX_SET_BITS-1:0]          q_set,
    input  logic [TAG_W-1:0]                 q_tag,
    input  logic                             q_dup,
    output logic                             q_pop,
    input  logic                             out_full,
    output logic                             res_push,
    output salc_pkg::result_t                res
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENTRY_W  = 1 + RANK_W + TAG_W;
    localparam int ROW_W    = MAX_WAYS * ENTRY_W;
    localparam int CW       = salc_pkg::COUNT_W;

    salc_pkg::back_state_t state_reg, state_next;

    logic                second_reg, second_next;
    logic                rowv_reg;
    logic [NUM_SETS-1:0] row_written_reg;
    logic [CW-1:0]       hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [CW-1:0]       hit_cnt_next, miss_cnt_next, evict_cnt_next;

    logic             start;
    logic             ram_re;
    logic             ram_we;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row_new;
    logic             is_last;

    logic [MAX_WAYS-1:0] v;
    logic [RANK_W-1:0]   r [MAX_WAYS];
    logic [TAG_W-1:0]    t [MAX_WAYS];
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic                found;
    logic                evict;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    victim;
    logic [WAY_W-1:0]    way_sel;
    logic [RANK_W-1:0]   rank_sel;

    assign start   = !q_empty && !out_full;
    assign row     = rowv_reg ? ram_rdata : '0;
    assign is_last = !q_dup || second_reg;

    salc_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_SETS)
    ) u_rows (
        .clk  (clk),
        .we   (ram_we),
        .waddr(q_set),
        .wdata(row_new),
        .re   (ram_re),
        .raddr(q_set),
        .rdata(ram_rdata)
    );

    // Unpack the row and classify every way
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            v[i]      = row[i*ENTRY_W + ENTRY_W - 1];
            r[i]      = row[i*ENTRY_W + TAG_W +: RANK_W];
            t[i]      = row[i*ENTRY_W +: TAG_W];
            in_use[i] = (WCNT_W'(i) < ways_eff);
            match[i]  = in_use[i] && v[i] && (t[i] == q_tag);
        end
    end

    always_comb
    begin
        logic [RANK_W-1:0] best_rank;
        hit       = 1'b0;
        found     = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        victim    = '0;
        best_rank = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (in_use[i] && !v[i])
            begin
                found   = 1'b1;
                inv_way = WAY_W'(i);
            end
        end
        // Highest-numbered way among those with the largest rank
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (in_use[i] && (r[i] >= best_rank))
            begin
                best_rank = r[i];
                victim    = WAY_W'(i);
            end
        end
    end

    assign evict    = !hit && !found;
    assign way_sel  = hit ? hit_way : (found ? inv_way : victim);
    assign rank_sel = r[way_sel];

    // Age the ways ranked ahead of the touched one (all valid ways in use on a fill), make it most recent
    always_comb
    begin
        logic [RANK_W-1:0] nr;
        logic              older;
        row_new = row;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            older = (hit || evict) ? (r[i] < rank_sel) : 1'b1;
            nr    = r[i];
            if (WAY_W'(i) == way_sel)
            begin
                nr = '0;
                row_new[i*ENTRY_W + ENTRY_W - 1] = 1'b1;
                row_new[i*ENTRY_W +: TAG_W]      = q_tag;
            end
            else if (in_use[i] && v[i] && older && (r[i] != RANK_W'(MAX_WAYS - 1)))
            begin
                nr = r[i] + RANK_W'(1);
            end
            row_new[i*ENTRY_W + TAG_W +: RANK_W] = nr;
        end
    end

    assign hit_cnt_next   = (hit && (hit_cnt_reg != '1)) ? hit_cnt_reg + CW'(1) : hit_cnt_reg;
    assign miss_cnt_next  = (!hit && (miss_cnt_reg != '1)) ? miss_cnt_reg + CW'(1)
                            : miss_cnt_reg;
    assign evict_cnt_next = (evict && (evict_cnt_reg != '1)) ? evict_cnt_reg + CW'(1)
                            : evict_cnt_reg;

    always_comb
    begin
        res.hit            = hit;
        res.miss           = !hit;
        res.eviction       = evict;
        res.last           = is_last;
        res.hit_total      = hit_cnt_next;
        res.miss_total     = miss_cnt_next;
        res.eviction_total = evict_cnt_next;
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        unique case (state_reg)
            salc_pkg::B_IDLE:
            begin
                if (start)
                begin
                    state_next = salc_pkg::B_LOOK;
                end
            end
            salc_pkg::B_LOOK:
            begin
                state_next  = salc_pkg::B_IDLE;
                second_next = !is_last;
            end
            default:
            begin
                state_next = salc_pkg::B_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ram_re   = 1'b0;
        ram_we   = 1'b0;
        res_push = 1'b0;
        q_pop    = 1'b0;
        unique case (state_reg)
            salc_pkg::B_IDLE:
            begin
                ram_re = start;
            end
            salc_pkg::B_LOOK:
            begin
                ram_we   = 1'b1;
                res_push = 1'b1;
                q_pop    = is_last;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= salc_pkg::B_IDLE;
            second_reg      <= 1'b0;
            rowv_reg        <= 1'b0;
            row_written_reg <= '0;
            hit_cnt_reg     <= '0;
            miss_cnt_reg    <= '0;
            evict_cnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            if (ram_re)
            begin
                rowv_reg <= row_written_reg[q_set];
            end
            if (res_push)
            begin
                row_written_reg[q_set] <= 1'b1;
                hit_cnt_reg            <= hit_cnt_next;
                miss_cnt_reg           <= miss_cnt_next;
                evict_cnt_reg          <= evict_cnt_next;
            end
        end
    end

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !out_full)
        else $error("result pushed into a full output queue");

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.eviction) |-> (res.miss && !res.hit))
        else $error("eviction reported without a miss");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (res_push && res.last))
        else $error("access record released before its final result");

    a_read_then_look: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> (state_reg == salc_pkg::B_LOOK))
        else $error("row read not followed by the update cycle");

endmodule

[rtl/set_assoc_lru_cache_sim_core.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core: set-associative tag store with true LRU
// Counts hits, misses and evictions of a stream of memory accesses.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as a queue: drive req_type and address, raise push while
//   full is low. Loads and stores give one result, modify gives two (the
//   second with last set), instruction fetches are taken and give none.
//   Results leave as a queue: while empty is low the oldest result is on the
//   result ports; raise pop to transfer it.
//   Configuration: cfg_valid/cfg_ready write set_bits (index 0), ways_in_use
//   (index 1) or block_bits (index 2); cfg_ready is always high. Write only
//   while no request is in flight.
// Flow:
//   The back end reads the set row of an access from the row RAM, then
//   resolves it and writes it back, and only then takes the next access;
//   a modify passes twice. A result goes through the request queue, the
//   back end and the output queue on its way to the result ports.
// Reset:
//   All lines read invalid with rank zero (per-set row flags, no clearing
//   pass), totals clear, registers return to 4 / 1 / 4.
// Stall:
//   A held result stops the back end once the output queue fills; the
//   request queue then fills and full rises.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_core #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF,
    parameter int ADDR_BITS    = salc_pkg::ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          req_type,
    input  logic [salc_pkg::ADDRESS_W-1:0]      address,
    // result channel
    output logic                                empty,
    input  logic                                pop,
    output logic                                hit,
    output logic                                miss,
    output logic                                eviction,
    output logic                                last,
    output logic [salc_pkg::COUNT_W-1:0]        hit_total,
    output logic [salc_pkg::COUNT_W-1:0]        miss_total,
    output logic [salc_pkg::COUNT_W-1:0]        eviction_total,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [salc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int EFF_BITS = (ADDR_BITS < salc_pkg::ADDRESS_W) ? ADDR_BITS
                              : salc_pkg::ADDRESS_W;
    localparam int TAG_W    = EFF_BITS - 2;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int RES_W    = $bits(salc_pkg::result_t);

    logic [3:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [4:0] block_bits_reg;

    logic [4:0]        set_bits_eff;
    logic [4:0]        block_bits_eff;
    logic [WCNT_W-1:0] ways_eff;

    logic                    q_pop;
    logic                    q_empty;
    logic [MAX_SET_BITS-1:0] q_set;
    logic [TAG_W-1:0]        q_tag;
    logic                    q_dup;

    logic              out_full;
    logic              res_push;
    salc_pkg::result_t res_in;
    salc_pkg::result_t res_out;
    logic [RES_W-1:0]  res_out_bits;

    // Registers take every write; an unknown index is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= salc_pkg::SET_BITS_RST;
            ways_reg       <= salc_pkg::WAYS_RST;
            block_bits_reg <= salc_pkg::BLOCK_BITS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                salc_pkg::REG_SET_BITS:   set_bits_reg   <= cfg_data[3:0];
                salc_pkg::REG_WAYS:       ways_reg       <= cfg_data[3:0];
                salc_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_data;
                default:                  set_bits_reg   <= set_bits_reg;
            endcase
        end
    end

    // Clamp registers into the range the hardware is built for
    assign set_bits_eff = (set_bits_reg == '0) ? 5'd1
                          : (set_bits_reg > MAX_SET_BITS) ? 5'(MAX_SET_BITS)
                          : {1'b0, set_bits_reg};
    assign block_bits_eff = (block_bits_reg == '0) ? 5'd1
                            : (block_bits_reg > salc_pkg::BLOCK_BITS_MAX)
                              ? 5'(salc_pkg::BLOCK_BITS_MAX)
                            : block_bits_reg;
    assign ways_eff = (ways_reg == '0) ? WCNT_W'(1)
                      : (ways_reg > MAX_WAYS) ? WCNT_W'(MAX_WAYS)
                      : WCNT_W'(ways_reg);

    // Front end: take requests, drop fetches, queue set/tag records
    salc_front #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .req_type      (req_type),
        .address       (address),
        .set_bits_eff  (set_bits_eff),
        .block_bits_eff(block_bits_eff),
        .q_pop         (q_pop),
        .q_empty       (q_empty),
        .q_set         (q_set),
        .q_tag         (q_tag),
        .q_dup         (q_dup)
    );

    // Back end: read-modify-write of one set row per access
    salc_back #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .MAX_WAYS    (MAX_WAYS),
        .TAG_W       (TAG_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ways_eff(ways_eff),
        .q_empty (q_empty),
        .q_set   (q_set),
        .q_tag   (q_tag),
        .q_dup   (q_dup),
        .q_pop   (q_pop),
        .out_full(out_full),
        .res_push(res_push),
        .res     (res_in)
    );

    // Output queue: hold finished results while the receiver stalls
    salc_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_out_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(res_in),
        .pop  (pop),
        .rdata(res_out_bits),
        .full (out_full),
        .empty(empty)
    );

    assign res_out        = salc_pkg::result_t'(res_out_bits);
    assign hit            = res_out.hit;
    assign miss           = res_out.miss;
    assign eviction       = res_out.eviction;
    assign last           = res_out.last;
    assign hit_total      = res_out.hit_total;
    assign miss_total     = res_out.miss_total;
    assign eviction_total = res_out.eviction_total;

endmodule
